// ===== hdl/psd_pkg.sv =====
// Shared types and constants for the photometric stereo depth unit.
// Used by psd_front, psd_queue, psd_back and the top level; no dependencies.
package psd_pkg;

   localparam int NUM_LIGHTS = 6;
   localparam int PIX_W      = 8;
   localparam int COEF_W     = 10;
   localparam int CFG_W      = NUM_LIGHTS * COEF_W;
   localparam int PROD_W     = COEF_W + PIX_W + 1;
   localparam int NORM_W     = 21;
   localparam int DVD_W      = NORM_W + 8;
   localparam int STEP_W     = 5;
   localparam int GRAD_W     = 16;
   localparam int DEPTH_W    = 32;
   localparam int IMG_W_W    = 13;
   localparam int CSR_IDX_W  = 3;
   localparam int IMAGE_WIDTH_RESET = 120;

   localparam logic signed [DEPTH_W-1:0] DEPTH_FLOOR = -32'sd25600;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEFF_X     = 3'd0,
      CSR_COEFF_Y     = 3'd1,
      CSR_COEFF_Z     = 3'd2,
      CSR_IMAGE_WIDTH = 3'd3
   } csr_index_type;

   // One classified pixel: frame start, mask flag and its normal vector
   typedef struct packed {
      logic                     sof;
      logic                     masked;
      logic signed [NORM_W-1:0] n1;
      logic signed [NORM_W-1:0] n2;
      logic signed [NORM_W-1:0] n3;
   } norm_item_type;

endpackage

// ===== hdl/photometric_stereo_depth_unit.sv =====
// Photometric stereo depth unit, top level: configuration registers, front
// end, queue and back end. Depends on psd_pkg, psd_front, psd_queue, psd_back.
//
// Usage: pixels arrive in raster order on the req_ channel, six grey levels
// each, start_of_frame set on the first pixel of an image. Each item yields
// one rsp_ item: depth (Q24.8) and the two slopes (Q8.8).
// The light matrix rows and the image width are written on the csr_ channel
// (index 0..2 coefficient rows, 3 image width) while the unit is idle;
// csr_ready is always high.
// The products are registered when a pixel is accepted, the item is
// written to the queue once it has room, and the back end pops it, runs 29
// division steps and retires it into the result register, raising rsp_valid.
// The back end takes a new item only after retiring the last one; its
// bit-serial divider forms both slopes one quotient bit per cycle.
// The front end and a two-entry queue keep taking up to three items while
// the back end divides. When rsp_stall is high the result register holds,
// the back end waits with its finished item, the queue fills and then
// req_stall rises. Reset clears the sums, counters, valids and sets the
// coefficients to zero and the width to 120.
module photometric_stereo_depth_unit #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_start_of_frame,
   input  logic [7:0]                            req_intensity_1,
   input  logic [7:0]                            req_intensity_2,
   input  logic [7:0]                            req_intensity_3,
   input  logic [7:0]                            req_intensity_4,
   input  logic [7:0]                            req_intensity_5,
   input  logic [7:0]                            req_intensity_6,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [31:0]                    rsp_depth,
   output logic signed [15:0]                    rsp_gradient_x,
   output logic signed [15:0]                    rsp_gradient_y,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [psd_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [psd_pkg::CFG_W-1:0]             csr_wdata
);

   localparam int WID_W = $clog2(MAX_WIDTH + 1);

   logic [2:0][psd_pkg::CFG_W-1:0]                       coeff_ff;
   logic [psd_pkg::IMG_W_W-1:0]                          image_width_ff;
   logic [WID_W-1:0]                                     row_width;
   logic [psd_pkg::NUM_LIGHTS-1:0][psd_pkg::PIX_W-1:0]   pix;
   logic                                                 q_full, q_push, q_pop;
   logic                                                 q_not_empty;
   psd_pkg::norm_item_type                               q_in_data, q_head;
   logic                                                 csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff       <= '0;
         image_width_ff <= psd_pkg::IMG_W_W'(psd_pkg::IMAGE_WIDTH_RESET);
      end else if (csr_write) begin
         case (csr_index)
            psd_pkg::CSR_COEFF_X:     coeff_ff[0]    <= csr_wdata;
            psd_pkg::CSR_COEFF_Y:     coeff_ff[1]    <= csr_wdata;
            psd_pkg::CSR_COEFF_Z:     coeff_ff[2]    <= csr_wdata;
            psd_pkg::CSR_IMAGE_WIDTH:
               image_width_ff <= csr_wdata[psd_pkg::IMG_W_W-1:0];
            default: ;
         endcase
      end
   end

   // Width zero acts as one, above the maximum acts as the maximum
   always_comb begin
      if (image_width_ff == '0)
         row_width = WID_W'(1);
      else if (32'(image_width_ff) > 32'(MAX_WIDTH))
         row_width = WID_W'(MAX_WIDTH);
      else
         row_width = WID_W'(image_width_ff);
   end

   assign pix[0] = req_intensity_1;
   assign pix[1] = req_intensity_2;
   assign pix[2] = req_intensity_3;
   assign pix[3] = req_intensity_4;
   assign pix[4] = req_intensity_5;
   assign pix[5] = req_intensity_6;

   psd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sof       (req_start_of_frame),
      .pix       (pix),
      .coeff     (coeff_ff),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_in_data)
   );

   psd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   psd_back #(
      .WID_W (WID_W)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_not_empty),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .row_width      (row_width),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_depth      (rsp_depth),
      .rsp_gradient_x (rsp_gradient_x),
      .rsp_gradient_y (rsp_gradient_y)
   );

endmodule

// ===== hdl/psd_front.sv =====
// Front end: accepts pixels, forms the three light-matrix products, sums them
// into a normal vector and pushes it to the queue. Depends on psd_pkg.
module psd_front (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  logic                                                  req_valid,
   output logic                                                  req_stall,
   input  logic                                                  sof,
   input  logic [psd_pkg::NUM_LIGHTS-1:0][psd_pkg::PIX_W-1:0]     pix,
   input  logic [2:0][psd_pkg::CFG_W-1:0]                        coeff,
   input  logic                                                  q_full,
   output logic                                                  q_push,
   output psd_pkg::norm_item_type                                q_data
);

   logic                                   s1_valid_ff, s1_valid_in;
   logic                                   s1_sof_ff;
   logic                                   s1_mask_ff;
   logic signed [psd_pkg::PROD_W-1:0]      prod_ff [3][psd_pkg::NUM_LIGHTS];
   logic signed [psd_pkg::PROD_W-1:0]      prod_in [3][psd_pkg::NUM_LIGHTS];
   logic signed [psd_pkg::NORM_W-1:0]      norm [3];
   logic                                   accept;

   // Stage holds one item; stall only when it cannot drain into the queue
   assign req_stall = s1_valid_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign q_push    = s1_valid_ff && !q_full;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept)
         s1_valid_in = 1'b1;
      else if (q_push)
         s1_valid_in = 1'b0;
   end

   // Coefficient times grey level, one product per light and row
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < psd_pkg::NUM_LIGHTS; k++) begin
            prod_in[r][k] = psd_pkg::PROD_W'(
               $signed(coeff[r][k*psd_pkg::COEF_W +: psd_pkg::COEF_W]) *
               $signed({1'b0, pix[k]}));
         end
      end
   end

   // Sum of products per row
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         norm[r] = '0;
         for (int k = 0; k < psd_pkg::NUM_LIGHTS; k++)
            norm[r] = norm[r] + psd_pkg::NORM_W'(prod_ff[r][k]);
      end
   end

   assign q_data.sof    = s1_sof_ff;
   assign q_data.masked = s1_mask_ff;
   assign q_data.n1     = norm[0];
   assign q_data.n2     = norm[1];
   assign q_data.n3     = norm[2];

   always_ff @(posedge clock) begin
      if (reset)
         s1_valid_ff <= 1'b0;
      else
         s1_valid_ff <= s1_valid_in;
      if (accept) begin
         s1_sof_ff  <= sof;
         s1_mask_ff <= (pix[0] == '0);
         prod_ff    <= prod_in;
      end
   end

endmodule

// ===== hdl/psd_queue.sv =====
// Two-entry queue of normal vectors between front and back end.
// Depends on psd_pkg for the item type.
module psd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  psd_pkg::norm_item_type push_data,
   input  logic                   pop,
   output logic                   full,
   output logic                   not_empty,
   output psd_pkg::norm_item_type head
);

   psd_pkg::norm_item_type mem_ff [2];
   logic                   wr_ptr_ff, wr_ptr_in;
   logic                   rd_ptr_ff, rd_ptr_in;
   logic [1:0]             count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = mem_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)
         count_in = count_ff + 2'd1;
      else if (pop && !push)
         count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push)
         mem_ff[wr_ptr_ff] <= push_data;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("queue count out of range");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop)) else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty) else $error("pop from empty queue");

endmodule

// ===== hdl/psd_back.sv =====
// Back end: bit-serial division for both slopes, saturation, running depth
// sums and the result register. Depends on psd_pkg.
module psd_back #(
   parameter int WID_W = 13
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  q_valid,
   input  psd_pkg::norm_item_type                q_head,
   output logic                                  q_pop,
   input  logic [WID_W-1:0]                      row_width,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [psd_pkg::DEPTH_W-1:0]    rsp_depth,
   output logic signed [psd_pkg::GRAD_W-1:0]     rsp_gradient_x,
   output logic signed [psd_pkg::GRAD_W-1:0]     rsp_gradient_y
);

   localparam int NW = psd_pkg::NORM_W;
   localparam int DW = psd_pkg::DVD_W;
   localparam int GW = psd_pkg::GRAD_W;
   localparam int AW = psd_pkg::DEPTH_W;

   typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_DONE} state_type;

   state_type                     state_ff, state_in;
   psd_pkg::norm_item_type        item_ff, item_in;
   logic [DW-1:0]                 dq_x_ff, dq_x_in, dq_y_ff, dq_y_in;
   logic [NW-1:0]                 rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;
   logic [NW-1:0]                 dvs_ff, dvs_in;
   logic [psd_pkg::STEP_W-1:0]    cnt_ff, cnt_in;
   logic signed [AW-1:0]          col_sum_ff, col_sum_in, row_sum_ff, row_sum_in;
   logic [WID_W-1:0]              idx_ff, idx_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [AW-1:0]          depth_ff, depth_in;
   logic signed [GW-1:0]          gx_ff, gx_in, gy_ff, gy_in;

   logic signed [GW-1:0]          gx, gy;
   logic signed [AW-1:0]          cs_base, rs_base, depth_val;
   logic [WID_W-1:0]              idx_base;
   logic [WID_W:0]                idx_next;
   logic                          load_out;

   function automatic logic [NW-1:0] mag(input logic signed [NW-1:0] v);
      mag = v[NW-1] ? NW'(-v) : NW'(v);
   endfunction

   // Quotient magnitude to saturated Q8.8 slope
   function automatic logic signed [GW-1:0] grad_sat(input logic [DW-1:0] q,
                                                      input logic neg,
                                                      input logic den_zero);
      if (den_zero)
         grad_sat = '0;
      else if (neg)
         grad_sat = (q > DW'(32768)) ? -16'sd32768 : GW'(-q);
      else
         grad_sat = (q > DW'(32767)) ? 16'sd32767 : GW'(q);
   endfunction

   function automatic logic signed [AW-1:0] sat_add(input logic signed [AW-1:0] a,
                                                    input logic signed [AW-1:0] b);
      logic signed [AW:0] s;
      s = (AW+1)'(a) + (AW+1)'(b);
      if (s > (AW+1)'(33'sh0_7FFF_FFFF))
         sat_add = 32'sh7FFF_FFFF;
      else if (s < -(AW+1)'(33'sh0_8000_0000))
         sat_add = -32'sh8000_0000;
      else
         sat_add = AW'(s);
   endfunction

   // One restoring-division step
   function automatic logic [NW+DW-1:0] div_step(input logic [NW-1:0] rem,
                                                 input logic [DW-1:0] dq,
                                                 input logic [NW-1:0] dvs);
      logic [NW:0] sh;
      logic [NW:0] diff;
      sh   = {rem, dq[DW-1]};
      diff = sh - {1'b0, dvs};
      if (!diff[NW])
         div_step = {diff[NW-1:0], dq[DW-2:0], 1'b1};
      else
         div_step = {sh[NW-1:0], dq[DW-2:0], 1'b0};
   endfunction

   // Finished item: slopes, depth from the sums before this pixel
   assign gx = grad_sat(dq_x_ff, (item_ff.n1 < 0) == (item_ff.n3 < 0), dvs_ff == '0);
   assign gy = grad_sat(dq_y_ff, (item_ff.n2 < 0) == (item_ff.n3 < 0), dvs_ff == '0);
   assign cs_base  = item_ff.sof ? '0 : col_sum_ff;
   assign rs_base  = item_ff.sof ? '0 : row_sum_ff;
   assign idx_base = item_ff.sof ? '0 : idx_ff;
   assign idx_next = {1'b0, idx_base} + (WID_W+1)'(1);

   always_comb begin
      depth_val = sat_add(cs_base, rs_base);
      if (item_ff.masked)
         depth_val = '0;
      if (depth_val < psd_pkg::DEPTH_FLOOR)
         depth_val = psd_pkg::DEPTH_FLOOR;
   end

   assign load_out = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // Sequencer: pop, divide one bit a cycle, then retire into the sums
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      dq_x_in      = dq_x_ff;
      dq_y_in      = dq_y_ff;
      rem_x_in     = rem_x_ff;
      rem_y_in     = rem_y_ff;
      dvs_in       = dvs_ff;
      cnt_in       = cnt_ff;
      col_sum_in   = col_sum_ff;
      row_sum_in   = row_sum_ff;
      idx_in       = idx_ff;
      depth_in     = depth_ff;
      gx_in        = gx_ff;
      gy_in        = gy_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      q_pop        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               item_in  = q_head;
               dq_x_in  = {mag(q_head.n1), 8'b0};
               dq_y_in  = {mag(q_head.n2), 8'b0};
               dvs_in   = mag(q_head.n3);
               rem_x_in = '0;
               rem_y_in = '0;
               cnt_in   = psd_pkg::STEP_W'(DW);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            {rem_x_in, dq_x_in} = div_step(rem_x_ff, dq_x_ff, dvs_ff);
            {rem_y_in, dq_y_in} = div_step(rem_y_ff, dq_y_ff, dvs_ff);
            cnt_in = cnt_ff - psd_pkg::STEP_W'(1);
            if (cnt_ff == psd_pkg::STEP_W'(1))
               state_in = ST_DONE;
         end
         ST_DONE: begin
            if (load_out) begin
               rsp_valid_in = 1'b1;
               depth_in     = depth_val;
               gx_in        = gx;
               gy_in        = gy;
               row_sum_in   = sat_add(rs_base, AW'(gx));
               col_sum_in   = (idx_base == '0) ? sat_add(cs_base, AW'(gy)) : cs_base;
               idx_in       = idx_base + WID_W'(1);
               if (idx_next >= {1'b0, row_width}) begin
                  idx_in     = '0;
                  row_sum_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         col_sum_ff   <= '0;
         row_sum_ff   <= '0;
         idx_ff       <= '0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         col_sum_ff   <= col_sum_in;
         row_sum_ff   <= row_sum_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
      end
      item_ff  <= item_in;
      dq_x_ff  <= dq_x_in;
      dq_y_ff  <= dq_y_in;
      rem_x_ff <= rem_x_in;
      rem_y_ff <= rem_y_in;
      dvs_ff   <= dvs_in;
      depth_ff <= depth_in;
      gx_ff    <= gx_in;
      gy_ff    <= gy_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_depth      = depth_ff;
   assign rsp_gradient_x = gx_ff;
   assign rsp_gradient_y = gy_ff;

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == ST_IDLE) else $error("pop while busy");
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> cnt_ff != '0) else $error("divider count lost");
   a_mask_depth: assert property (@(posedge clock) disable iff (reset)
      (load_out && item_ff.masked) |=> rsp_depth == '0)
      else $error("masked pixel with nonzero depth");
   a_depth_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_depth >= psd_pkg::DEPTH_FLOOR)
      else $error("depth below floor");

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for photometric_stereo_depth_unit: pixel streams with
// random gaps and back-pressure, checked against an in-bench depth predictor.
// Depends on psd_pkg and the photometric_stereo_depth_unit RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 6000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int EFF_MAX_WIDTH  = 4096;

   typedef struct {
      logic signed [31:0] depth;
      logic signed [15:0] grad_x;
      logic signed [15:0] grad_y;
   } depth_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_start_of_frame = 1'b0;
   logic [7:0] req_intensity_1 = '0, req_intensity_2 = '0, req_intensity_3 = '0;
   logic [7:0] req_intensity_4 = '0, req_intensity_5 = '0, req_intensity_6 = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_depth;
   logic signed [15:0] rsp_gradient_x, rsp_gradient_y;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [psd_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [psd_pkg::CFG_W-1:0] csr_wdata = '0;

   // predictor copy of configuration and state
   logic [psd_pkg::CFG_W-1:0] coef_x = '0, coef_y = '0, coef_z = '0;
   logic [psd_pkg::IMG_W_W-1:0] width_cfg =
      psd_pkg::IMG_W_W'(psd_pkg::IMAGE_WIDTH_RESET);
   longint column_acc = 0, row_acc = 0;
   int unsigned pixel_col = 0;

   depth_result_type expected_pixels[$];
   int error_count = 0;
   int idle_cycles = 0;
   bit quiet = 1'b0;
   int hold_request = 0;
   int stall_left = 0;

   photometric_stereo_depth_unit i_dut (.*);

   always #6 clock = ~clock;

   task automatic report(input string what);
      $display("mismatch @%0t: %s", $time, what);
      error_count++;
   endtask

   function automatic longint normal_dot(input logic [psd_pkg::CFG_W-1:0] row,
                                         input logic [47:0] px);
      longint acc, cf, p;
      acc = 0;
      for (int k = 0; k < psd_pkg::NUM_LIGHTS; k++) begin
         cf = longint'($signed(row[10*k +: 10]));
         p = longint'(px[8*k +: 8]);
         acc += cf * p;
      end
      return acc;
   endfunction

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint slope_q88(input longint num, input longint den);
      if (den == 0) return 0;
      return clamp((-num * 256) / den, -32768, 32767);
   endfunction

   // depth integration for one accepted pixel
   task automatic predict_depth(input bit sof, input logic [47:0] px);
      longint n1, n2, n3, gx, gy, d, w;
      depth_result_type r;
      if (sof) begin
         column_acc = 0;
         row_acc = 0;
         pixel_col = 0;
      end
      n1 = normal_dot(coef_x, px);
      n2 = normal_dot(coef_y, px);
      n3 = normal_dot(coef_z, px);
      gx = slope_q88(n1, n3);
      gy = slope_q88(n2, n3);
      d = column_acc + row_acc;
      if (px[7:0] == 0) d = 0;
      d = clamp(d, psd_pkg::DEPTH_FLOOR, 64'sd2147483647);
      row_acc = clamp(row_acc + gx, -64'sd2147483648, 64'sd2147483647);
      if (pixel_col == 0)
         column_acc = clamp(column_acc + gy, -64'sd2147483648, 64'sd2147483647);
      w = longint'(width_cfg);
      if (w < 1) w = 1;
      if (w > EFF_MAX_WIDTH) w = EFF_MAX_WIDTH;
      pixel_col++;
      if (pixel_col >= w) begin
         pixel_col = 0;
         row_acc = 0;
      end
      r.depth = d[31:0];
      r.grad_x = gx[15:0];
      r.grad_y = gy[15:0];
      expected_pixels.push_back(r);
   endtask

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic send_pixel(input bit sof, input logic [47:0] px);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_start_of_frame <= sof;
      req_intensity_1 <= px[7:0];
      req_intensity_2 <= px[15:8];
      req_intensity_3 <= px[23:16];
      req_intensity_4 <= px[31:24];
      req_intensity_5 <= px[39:32];
      req_intensity_6 <= px[47:40];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_depth(sof, px);
   endtask

   // stop offering and wait for every expected result, then let the pipe settle
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input psd_pkg::csr_index_type idx,
                            input logic [psd_pkg::CFG_W-1:0] val);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         psd_pkg::CSR_COEFF_X:     coef_x = val;
         psd_pkg::CSR_COEFF_Y:     coef_y = val;
         psd_pkg::CSR_COEFF_Z:     coef_z = val;
         psd_pkg::CSR_IMAGE_WIDTH: width_cfg = val[psd_pkg::IMG_W_W-1:0];
         default: ;
      endcase
   endtask

   function automatic logic [psd_pkg::CFG_W-1:0] pack_row(input int c0, c1, c2,
                                                          c3, c4, c5);
      logic [psd_pkg::CFG_W-1:0] row;
      row = '0;
      row[9:0] = c0[9:0];
      row[19:10] = c1[9:0];
      row[29:20] = c2[9:0];
      row[39:30] = c3[9:0];
      row[49:40] = c4[9:0];
      row[59:50] = c5[9:0];
      return row;
   endfunction

   function automatic logic [psd_pkg::CFG_W-1:0] random_row(input int mode,
                                                            input bit z_row);
      logic [psd_pkg::CFG_W-1:0] row;
      int pick[5] = '{-512, 511, 0, 1, -1};
      row = psd_pkg::CFG_W'({$urandom, $urandom});
      for (int k = 0; k < psd_pkg::NUM_LIGHTS; k++) begin
         case (mode)
            1: row[10*k +: 10] = z_row ? 10'($urandom_range(60, 255))
                                       : 10'(int'($urandom_range(0, 120)) - 60);
            2: if (z_row) row[10*k +: 10] = '0;
            3: row[10*k +: 10] = 10'(pick[$urandom_range(0, 4)]);
            default: ;
         endcase
      end
      return row;
   endfunction

   function automatic logic [47:0] random_pixel();
      logic [47:0] px;
      int r;
      px = 48'({$urandom, $urandom});
      r = $urandom_range(0, 99);
      if (r < 6) px[7:0] = 8'd0;
      else if (r < 9) px = '0;
      else if (r < 12) px = '1;
      return px;
   endfunction

   // extremes of coefficients and intensities, masked pixel, zero normal z
   task automatic test_directed();
      csr_write(psd_pkg::CSR_COEFF_X, pack_row(511, 511, 511, 511, 511, 511));
      csr_write(psd_pkg::CSR_COEFF_Y, pack_row(-512, -512, -512, -512, -512, -512));
      csr_write(psd_pkg::CSR_COEFF_Z, pack_row(1, 0, 0, 0, 0, 0));
      csr_write(psd_pkg::CSR_IMAGE_WIDTH, 60'd3);
      send_pixel(1'b1, '1);
      send_pixel(1'b0, 48'h00_00_00_00_00_01);
      send_pixel(1'b0, 48'hFF_FF_FF_FF_FF_00);
      send_pixel(1'b0, '0);
      send_pixel(1'b0, 48'h80_40_20_10_08_02);
      send_pixel(1'b0, 48'h7F_7F_7F_7F_7F_FF);
      send_pixel(1'b1, 48'h01_01_01_01_01_01);
      send_pixel(1'b0, 48'hFF_00_FF_00_FF_01);
      csr_write(psd_pkg::CSR_COEFF_Z, '0);
      send_pixel(1'b1, '1);
      send_pixel(1'b0, 48'h12_34_56_78_9A_BC);
      send_pixel(1'b0, 48'h00_00_00_00_00_00);
      csr_write(psd_pkg::CSR_COEFF_Z, pack_row(200, 200, 200, 200, 200, 200));
      csr_write(psd_pkg::CSR_COEFF_X, pack_row(-30, 20, 0, 5, -1, 40));
      csr_write(psd_pkg::CSR_COEFF_Y, pack_row(10, -10, 25, -25, 0, 1));
      csr_write(psd_pkg::CSR_IMAGE_WIDTH, 60'd0);
      send_pixel(1'b1, '1);
      send_pixel(1'b0, 48'h40_40_40_40_40_40);
      send_pixel(1'b0, 48'h40_40_40_40_40_00);
      send_pixel(1'b0, '1);
   endtask

   // frames under a run of coefficient and width settings
   task automatic test_random_frames();
      int widths[8] = '{1, 2, 5, 0, 17, 120, 3, 9};
      int w, n, rows, mode;
      for (int s = 0; s < 8; s++) begin
         mode = s % 4;
         csr_write(psd_pkg::CSR_COEFF_X, random_row(mode, 1'b0));
         csr_write(psd_pkg::CSR_COEFF_Y, random_row(mode, 1'b0));
         csr_write(psd_pkg::CSR_COEFF_Z, random_row(mode, 1'b1));
         csr_write(psd_pkg::CSR_IMAGE_WIDTH,
                   psd_pkg::CFG_W'({$urandom, $urandom}) & ~60'h1FFF | 60'(widths[s]));
         w = widths[s] < 1 ? 1 : widths[s];
         n = 0;
         while (n < 150) begin
            rows = w > 50 ? 1 : $urandom_range(1, 5);
            for (int p = 0; p < w * rows; p++) begin
               if (p == 0) send_pixel($urandom_range(0, 9) != 0, random_pixel());
               else send_pixel($urandom_range(0, 39) == 0, random_pixel());
               n++;
            end
         end
      end
   endtask

   // widest rows, including widths above the supported maximum
   task automatic test_wide_rows();
      int widths[3] = '{4096, 8191, 4097};
      csr_write(psd_pkg::CSR_COEFF_X, random_row(1, 1'b0));
      csr_write(psd_pkg::CSR_COEFF_Y, random_row(1, 1'b0));
      csr_write(psd_pkg::CSR_COEFF_Z, random_row(1, 1'b1));
      for (int s = 0; s < 3; s++) begin
         csr_write(psd_pkg::CSR_IMAGE_WIDTH, 60'(widths[s]));
         send_pixel(1'b1, random_pixel());
         repeat (35) send_pixel(1'b0, random_pixel());
      end
   endtask

   // receiver holds off long while the sender keeps offering back to back
   task automatic test_backpressure();
      csr_write(psd_pkg::CSR_IMAGE_WIDTH, 60'd7);
      quiet = 1'b1;
      hold_request = 300;
      send_pixel(1'b1, random_pixel());
      repeat (30) send_pixel(1'b0, random_pixel());
      drain();
      repeat (40) send_pixel(1'b0, random_pixel());
      drain();
      quiet = 1'b0;
   endtask

   // result side back-pressure
   always @(posedge clock) begin
      if (hold_request > 0) begin
         stall_left = hold_request;
         hold_request = 0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else begin
         int r;
         r = $urandom_range(0, 99);
         if (r < 75) rsp_stall <= 1'b0;
         else begin
            rsp_stall <= 1'b1;
            stall_left = r < 97 ? $urandom_range(0, 3) : $urandom_range(20, 80);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            report("result with no pixel pending");
         end else begin
            depth_result_type e;
            e = expected_pixels.pop_front();
            if (rsp_depth !== e.depth)
               report($sformatf("depth got %0d exp %0d", rsp_depth, e.depth));
            if (rsp_gradient_x !== e.grad_x)
               report($sformatf("gradient_x got %0d exp %0d", rsp_gradient_x, e.grad_x));
            if (rsp_gradient_y !== e.grad_y)
               report($sformatf("gradient_y got %0d exp %0d", rsp_gradient_y, e.grad_y));
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_frames();
      test_wide_rows();
      test_backpressure();
      drain();
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/psd_pkg.sv
hdl/psd_front.sv
hdl/psd_queue.sv
hdl/psd_back.sv
hdl/photometric_stereo_depth_unit.sv
dv/tb.sv
